[hw/rtl/ppba_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and sizes of the port pair bitmap allocator
package ppba_pkg;

  localparam int DATA_W        = 16;
  localparam int DIGIT_W       = 4;
  localparam int DIGITS        = DATA_W / DIGIT_W;
  localparam int WORD_W        = 16;
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int PCNT_W        = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int DEF_MAX_PAIRS = 64;

  localparam logic [DATA_W-1:0] RST_MIN_PORT   = 16'd0;
  localparam logic [PCNT_W-1:0] RST_PAIR_COUNT = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PORT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = 1'd1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_BAD_PORT     = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [DATA_W-1:0] port_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] port_out;
    status_t           status;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic sub;
  } ser_ctrl_t;

  typedef struct packed {
    logic done;
    logic carry;
  } ser_stat_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bm_ctrl_t;

endpackage

[hw/rtl/ppba_serial_addsub.sv]
`timescale 1ns / 1ps
// digit-serial adder and subtractor, one digit per cycle, low digit first
module ppba_serial_addsub (
  input  logic                           clk,
  input  logic                           rst,
  input  ppba_pkg::ser_ctrl_t            ctrl,
  input  logic [ppba_pkg::DATA_W-1:0]    a,
  input  logic [ppba_pkg::DATA_W-1:0]    b,
  output ppba_pkg::ser_stat_t            stat,
  output logic [ppba_pkg::DATA_W-1:0]    result
);
  import ppba_pkg::*;

  localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [DATA_W-1:0]  a_sr;
  logic [DATA_W-1:0]  b_sr;
  logic [DATA_W-1:0]  r_sr;
  logic               carry;
  logic               running;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [DIGIT_W:0]   dsum;

  assign dsum = {1'b0, a_sr[DIGIT_W-1:0]} + {1'b0, b_sr[DIGIT_W-1:0]}
              + {{DIGIT_W{1'b0}}, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIGITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // subtract as a + ~b + 1, the carry in provides the +1
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a_sr  <= a;
      b_sr  <= ctrl.sub ? ~b : b;
      carry <= ctrl.sub;
    end else if (running) begin
      a_sr  <= a_sr >> DIGIT_W;
      b_sr  <= b_sr >> DIGIT_W;
      r_sr  <= {dsum[DIGIT_W-1:0], r_sr[DATA_W-1:DIGIT_W]};
      carry <= dsum[DIGIT_W];
    end
  end

  assign stat.done  = done;
  assign stat.carry = carry;
  assign result     = r_sr;

endmodule

[hw/rtl/ppba_bitmap.sv]
`timescale 1ns / 1ps
// pair-used bitmap stored as words, with a valid bit per word for reset
module ppba_bitmap #(
  parameter int NUM_WORDS = 4
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ppba_pkg::bm_ctrl_t                         ctrl,
  input  logic [((NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1)-1:0] addr,
  input  logic [ppba_pkg::WORD_W-1:0]                wr_data,
  output logic [ppba_pkg::WORD_W-1:0]                rd_data
);
  import ppba_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;

  // a word never written reads as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ctrl.wr_en) begin
      row_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= row_valid[addr] ? mem[addr] : '0;
    end
  end

endmodule

[hw/rtl/port_pair_bitmap_allocator_unit.sv]
`timescale 1ns / 1ps
// port pair bitmap allocator: first-fit pair allocation and port release
// One request is served at a time. An allocate scans the bitmap one 16-pair word at a time
// (read, check), then forms min_port + 2 * index in a 4-bit digit-serial adder; when no
// pair is free it answers without the adder. A free subtracts min_port in the same
// digit-serial unit, checks the range, then reads the word and rewrites it if the pair
// was in use; a port out of range skips the read. The bitmap clears at reset with no
// sweep. The response sits in an output register, so a new request is taken while the
// last word is still held there.
module port_pair_bitmap_allocator_unit #(
  parameter int MAX_PAIRS = ppba_pkg::DEF_MAX_PAIRS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  ppba_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output ppba_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppba_pkg::DATA_W-1:0]       cfg_data
);
  import ppba_pkg::*;

  localparam int NUM_WORDS = (MAX_PAIRS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PIDX_W    = WADDR_W + BIT_W;
  localparam int NX_W      = PIDX_W + 1;
  localparam int NH_W      = WADDR_W + 1;
  localparam int CMP_W     = (NX_W > PCNT_W) ? NX_W : PCNT_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ARD  = 8'b0000_0010,
    S_ACHK = 8'b0000_0100,
    S_SER  = 8'b0000_1000,
    S_FCHK = 8'b0001_0000,
    S_FRD  = 8'b0010_0000,
    S_FUPD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [DATA_W-1:0]   min_port;
  logic [PCNT_W-1:0]   pair_count;
  func_t               op;
  logic [WADDR_W-1:0]  word;
  logic [BIT_W-1:0]    bitsel;
  logic [DATA_W-1:0]   res_port;
  status_t             res_status;

  logic                req_acc;
  logic                out_free;
  logic [CMP_W-1:0]    pc_x;
  logic [CMP_W-1:0]    max_x;
  logic [NX_W-1:0]     n;
  logic [NH_W-1:0]     n_hi;
  logic [BIT_W-1:0]    n_lo;
  logic [NH_W-1:0]     w_x;
  logic [NH_W-1:0]     w_inc;
  logic                next_live;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   free_vec;
  logic                found;
  logic [BIT_W-1:0]    fbit;
  logic                bad;

  ser_ctrl_t           ser_ctrl;
  ser_stat_t           ser_stat;
  logic [DATA_W-1:0]   ser_a;
  logic [DATA_W-1:0]   ser_b;
  logic [DATA_W-1:0]   ser_result;

  bm_ctrl_t            bm_ctrl;
  logic [WORD_W-1:0]   bm_wr_data;
  logic [WORD_W-1:0]   bm_rd_data;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;

  // pairs in use: min(pair_count, MAX_PAIRS)
  assign pc_x  = CMP_W'(pair_count);
  assign max_x = CMP_W'(MAX_PAIRS);
  assign n     = NX_W'((pc_x < max_x) ? pc_x : max_x);
  assign n_hi  = n[NX_W-1:BIT_W];
  assign n_lo  = n[BIT_W-1:0];

  assign w_x       = NH_W'(word);
  assign w_inc     = w_x + NH_W'(1);
  assign next_live = (w_inc < n_hi) || ((w_inc == n_hi) && (n_lo != '0));

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      if (w_x < n_hi) begin
        mask[i] = 1'b1;
      end else if (w_x == n_hi) begin
        mask[i] = (BIT_W'(i) < n_lo);
      end else begin
        mask[i] = 1'b0;
      end
    end
  end

  assign free_vec = ~bm_rd_data & mask;
  assign found    = |free_vec;

  // lowest free pair of the word
  always_comb begin
    fbit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        fbit = BIT_W'(i);
      end
    end
  end

  // no carry out (a borrow) means port < min_port; a pair index at or above n is also bad
  assign bad = !ser_stat.carry
            || ({1'b0, ser_result[DATA_W-1:1]} >= DATA_W'(n));

  assign ser_ctrl.start = (req_acc && (req.func == FN_FREE)) || ((state == S_ACHK) && found);
  assign ser_ctrl.sub   = (state == S_IDLE);
  assign ser_a          = (state == S_IDLE) ? req.port_in : min_port;
  assign ser_b          = (state == S_IDLE) ? min_port : DATA_W'({word, fbit, 1'b0});

  assign bm_ctrl.rd_en = (state == S_ARD) || (state == S_FRD);
  assign bm_ctrl.wr_en = ((state == S_ACHK) && found)
                      || ((state == S_FUPD) && bm_rd_data[bitsel]);
  assign bm_wr_data    = (state == S_ACHK) ? (bm_rd_data | (WORD_W'(1) << fbit))
                                           : (bm_rd_data & ~(WORD_W'(1) << bitsel));

  ppba_serial_addsub u_addsub (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ser_ctrl),
    .a      (ser_a),
    .b      (ser_b),
    .stat   (ser_stat),
    .result (ser_result)
  );

  ppba_bitmap #(
    .NUM_WORDS (NUM_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (bm_ctrl),
    .addr    (word),
    .wr_data (bm_wr_data),
    .rd_data (bm_rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          state_next = (req.func == FN_ALLOC) ? S_ARD : S_SER;
        end
      end
      S_ARD: state_next = S_ACHK;
      S_ACHK: begin
        if (found) begin
          state_next = S_SER;
        end else if (next_live) begin
          state_next = S_ARD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SER: begin
        if (ser_stat.done) begin
          state_next = (op == FN_ALLOC) ? S_DONE : S_FCHK;
        end
      end
      S_FCHK: state_next = bad ? S_DONE : S_FRD;
      S_FRD:  state_next = S_FUPD;
      S_FUPD: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_port   <= RST_MIN_PORT;
      pair_count <= RST_PAIR_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_PORT:   min_port   <= cfg_data;
        REG_PAIR_COUNT: pair_count <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      op   <= req.func;
      word <= '0;
    end
    unique case (state)
      S_ACHK: begin
        if (!found && next_live) begin
          word <= word + WADDR_W'(1);
        end else if (!found) begin
          res_port   <= '0;
          res_status <= ST_NO_FREE;
        end
      end
      S_SER: begin
        if (ser_stat.done && (op == FN_ALLOC)) begin
          res_port   <= ser_result;
          res_status <= ST_OK;
        end
      end
      S_FCHK: begin
        res_port   <= '0;
        res_status <= ST_BAD_PORT;
        word       <= ser_result[PIDX_W:BIT_W+1];
        bitsel     <= ser_result[BIT_W:1];
      end
      S_FUPD: begin
        res_port   <= '0;
        res_status <= bm_rd_data[bitsel] ? ST_OK : ST_ALREADY_FREE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      rsp.port_out <= res_port;
      rsp.status   <= res_status;
    end
  end

  // a new response word only comes from a finished request
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised without a finished request");

  // the serial unit finishes only while the controller waits for it
  a_ser_done_in_ser: assert property (@(posedge clk) disable iff (rst)
    ser_stat.done |-> (state == S_SER))
    else $error("serial result arrived outside the wait state");

  // an accepted request leaves idle on the next edge
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> (state == S_ARD) || (state == S_SER))
    else $error("accepted request did not start");

  // a found free pair always goes to the adder and the bitmap together
  a_alloc_write: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ACHK) && found) |-> (bm_ctrl.wr_en && ser_ctrl.start))
    else $error("allocation did not mark the pair and start the add");

endmodule

[sim/pair_alloc_checker.sv]
`timescale 1ns / 1ps
// checker for the port pair allocator: tracks pair use, predicts each response word, compares
module pair_alloc_checker #(
  parameter int MAX_PAIRS = ppba_pkg::DEF_MAX_PAIRS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  ppba_pkg::req_t                 req,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  ppba_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ppba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppba_pkg::DATA_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import ppba_pkg::*;

  logic [DATA_W-1:0]    pool_base;
  logic [PCNT_W-1:0]    pool_pairs;
  bit   [MAX_PAIRS-1:0] pair_taken;
  rsp_t                 due_words[$];

  // first-fit allocate or release, updating the pair bitmap
  function automatic rsp_t serve_request(req_t r);
    rsp_t res;
    int   live;
    int   slot;
    bit   found;
    live         = (int'(pool_pairs) < MAX_PAIRS) ? int'(pool_pairs) : MAX_PAIRS;
    res.port_out = '0;
    found        = 1'b0;
    if (r.func == FN_ALLOC) begin
      res.status = ST_NO_FREE;
      for (int i = 0; i < live; i++) begin
        if (!found && !pair_taken[i]) begin
          found         = 1'b1;
          pair_taken[i] = 1'b1;
          res.port_out  = pool_base + DATA_W'(2 * i);
          res.status    = ST_OK;
        end
      end
    end else if (r.port_in < pool_base) begin
      res.status = ST_BAD_PORT;
    end else begin
      slot = (int'(r.port_in) - int'(pool_base)) / 2;
      if (slot >= live) begin
        res.status = ST_BAD_PORT;
      end else if (!pair_taken[slot]) begin
        res.status = ST_ALREADY_FREE;
      end else begin
        pair_taken[slot] = 1'b0;
        res.status       = ST_OK;
      end
    end
    return res;
  endfunction

  function automatic void log_fault(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      pool_base  = RST_MIN_PORT;
      pool_pairs = RST_PAIR_COUNT;
      pair_taken = '0;
      due_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_PORT) begin
          pool_base = cfg_data;
        end else if (cfg_index == REG_PAIR_COUNT) begin
          pool_pairs = cfg_data[PCNT_W-1:0];
        end
      end
      // the response word always belongs to an older request, so check before pushing
      if (rsp_valid && !rsp_stall) begin
        if (due_words.size() == 0) begin
          log_fault($sformatf("unexpected word: port %0d status %0d",
                              rsp.port_out, rsp.status));
        end else begin
          want = due_words.pop_front();
          if (rsp.port_out !== want.port_out || rsp.status !== want.status) begin
            log_fault($sformatf("word mismatch: expected port %0d status %s, got port %0d status %0d",
                                want.port_out, want.status.name(), rsp.port_out, rsp.status));
          end
        end
      end
      if (req_valid && !req_stall) due_words.push_back(serve_request(req));
    end
    pending = due_words.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// testbench top: request and config stimulus for the port pair allocator, and the verdict
module tb;
  import ppba_pkg::*;

  localparam int RUN_LIMIT   = 1000000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 145;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rsp_t                 rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          long_hold_req = 1'b0;
  logic [15:0] cur_min;
  int          cur_cnt;

  port_pair_bitmap_allocator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pair_alloc_checker #(.MAX_PAIRS(DEF_MAX_PAIRS)) chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // response side: random stall bursts, plus a long hold each time the request flag toggles
  initial begin
    int burst;
    int hold;
    bit hold_seen;
    burst     = 0;
    hold      = 0;
    hold_seen = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req != hold_seen) begin
        hold      = 300;
        hold_seen = long_hold_req;
      end
      if (hold > 0) begin
        hold--;
        rsp_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        rsp_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 13);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input func_t f, input logic [15:0] p);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= '{func: f, port_in: p};
    do @(posedge clk); while (req_stall);
  endtask

  // stop offering requests until every response word is back
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pool(input logic [15:0] first, input int count);
    drain();
    cfg_write(REG_MIN_PORT, first);
    cfg_write(REG_PAIR_COUNT, DATA_W'(count));
    cur_min = first;
    cur_cnt = count;
  endtask

  // mostly allocates and frees inside the pool, some edge ports and stray ports
  task automatic send_random();
    int          pick;
    int          span;
    logic [15:0] p;
    span = ((cur_cnt < DEF_MAX_PAIRS) ? cur_cnt : DEF_MAX_PAIRS) * 2;
    pick = $urandom_range(0, 99);
    p    = 16'($urandom);
    if (pick < 48) begin
      send_word(FN_ALLOC, p);
    end else if (pick < 85 && span > 0) begin
      send_word(FN_FREE, cur_min + 16'($urandom_range(0, span - 1)));
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0: p = cur_min - 16'd1;
        1: p = cur_min + 16'(span);
        2: p = cur_min + 16'(span) - 16'd1;
        default: p = cur_min;
      endcase
      send_word(FN_FREE, p);
    end else begin
      send_word(FN_FREE, p);
    end
  endtask

  initial begin
    logic [15:0] nmin;
    int          ncnt;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    cur_min    = RST_MIN_PORT;
    cur_cnt    = int'(RST_PAIR_COUNT);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset pool of 64 pairs at port 0
    send_word(FN_ALLOC, 16'hFFFF);
    send_word(FN_ALLOC, 16'h0000);
    send_word(FN_ALLOC, 16'hA5A5);
    send_word(FN_FREE, 16'd2);
    send_word(FN_FREE, 16'd2);      // double free
    send_word(FN_FREE, 16'd3);      // odd port, same pair as 2
    send_word(FN_ALLOC, 16'd0);     // lowest free pair again
    send_word(FN_FREE, 16'd5);      // odd port frees its pair
    send_word(FN_FREE, 16'd127);    // last pair, never taken
    send_word(FN_FREE, 16'd128);    // just past the pool
    send_word(FN_FREE, 16'hFFFF);
    set_pool(16'd100, 2);
    send_word(FN_FREE, 16'd99);     // just below the first port
    send_word(FN_FREE, 16'd100);
    send_word(FN_ALLOC, 16'd0);
    send_word(FN_ALLOC, 16'd0);
    send_word(FN_ALLOC, 16'd0);     // pool full
    send_word(FN_FREE, 16'd104);
    set_pool(16'd100, 0);           // empty pool
    send_word(FN_ALLOC, 16'd0);
    send_word(FN_FREE, 16'd100);
    set_pool(16'd65530, 64);        // pool wraps past 65535, allocations reach 65534
    send_word(FN_ALLOC, 16'd0);
    send_word(FN_ALLOC, 16'd0);
    send_word(FN_ALLOC, 16'd0);
    send_word(FN_FREE, 16'd65535);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin nmin = 16'd0; ncnt = 64; end
        1: begin nmin = 16'hFFFF; ncnt = 1; end
        2: begin nmin = 16'd65400; ncnt = 64; end
        3: begin nmin = 16'($urandom); ncnt = 0; end
        4: begin nmin = 16'($urandom_range(0, 60000)); ncnt = 127; end
        5: begin nmin = 16'($urandom); ncnt = 3; end
        6: begin nmin = 16'($urandom_range(0, 65000)); ncnt = 64; end
        7: begin nmin = cur_min; ncnt = 8; end   // shrink, upper bits stay set
        8: begin nmin = cur_min; ncnt = 64; end  // grow back
        default: begin nmin = 16'($urandom); ncnt = $urandom_range(1, 16); end
      endcase
      set_pool(nmin, ncnt);
      tx_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 2 && k == 30) long_hold_req = !long_hold_req;
        if (ph == 5 && k == 70) drain();
        send_random();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ppba_pkg.sv
hw/rtl/ppba_serial_addsub.sv
hw/rtl/ppba_bitmap.sv
hw/rtl/port_pair_bitmap_allocator_unit.sv
sim/pair_alloc_checker.sv
sim/tb.sv
